@@ src/gffp_pkg.sv @@
`timescale 1ns / 1ps
package gffp_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLUMNS = 16;

   localparam int ROW_W      = 6;
   localparam int PTR_W      = ROW_W + 1;
   localparam int END_W      = PTR_W + 1;
   localparam int COL_W      = 4;
   localparam int CNT_W      = COL_W + 1;
   localparam int RSPAN_W    = 7;
   localparam int CSPAN_W    = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_COLUMN_COUNT = 1'b0;
   localparam logic REG_DENSE_MODE   = 1'b1;

   localparam logic REQ_PLACE = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      PTR_EXPLICIT,
      PTR_SCAN,
      PTR_COMMIT
   } ptr_sel_type;

   typedef struct packed {
      logic        load;
      logic        clear;
      logic        ptr_load;
      ptr_sel_type ptr_sel;
      logic        ex_rd;
      logic        scan_rd;
      logic        commit_rd;
      logic        take_explicit;
      logic        mark_overflow;
      logic        cursor_update;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic explicit_req;
      logic ex_done;
      logic ex_fit;
      logic ex_overflow;
      logic scan_done;
      logic scan_found;
      logic commit_done;
   } status_type;

   function automatic logic [MAX_COLUMNS-1:0] span_mask(input logic [COL_W-1:0] column,
                                                       input logic [CSPAN_W-1:0] cspan);
      logic [MAX_COLUMNS:0] ones;
      ones = ({{MAX_COLUMNS{1'b0}}, 1'b1} << cspan) - {{MAX_COLUMNS{1'b0}}, 1'b1};
      return ones[MAX_COLUMNS-1:0] << column;
   endfunction

endpackage

@@ src/gffp_controller.sv @@
`timescale 1ns / 1ps
module gffp_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_fire,
   input  logic                  req_clear,
   input  logic                  rsp_slot_free,
   input  gffp_pkg::status_type  status,
   output logic                  req_ready,
   output gffp_pkg::cmd_type     cmd
);
   import gffp_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXPL   = 7'b0000010,
      ST_SINIT  = 7'b0000100,
      ST_SCAN   = 7'b0001000,
      ST_CINIT  = 7'b0010000,
      ST_COMMIT = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.ptr_sel = PTR_EXPLICIT;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               if (req_clear) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_RESP;
               end else if (status.explicit_req) begin
                  cmd.ptr_load = 1'b1;
                  cmd.ptr_sel  = PTR_EXPLICIT;
                  state_in     = ST_EXPL;
               end else begin
                  state_in = ST_SINIT;
               end
            end
         end
         ST_EXPL: begin
            cmd.ex_rd = 1'b1;
            if (status.ex_done) begin
               if (status.ex_fit && status.ex_overflow) begin
                  cmd.mark_overflow = 1'b1;
                  state_in          = ST_RESP;
               end else if (status.ex_fit) begin
                  cmd.take_explicit = 1'b1;
                  state_in          = ST_CINIT;
               end else begin
                  state_in = ST_SINIT;
               end
            end
         end
         ST_SINIT: begin
            cmd.ptr_load = 1'b1;
            cmd.ptr_sel  = PTR_SCAN;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_done) begin
               if (status.scan_found) begin
                  state_in = ST_CINIT;
               end else begin
                  cmd.mark_overflow = 1'b1;
                  state_in          = ST_RESP;
               end
            end
         end
         ST_CINIT: begin
            cmd.ptr_load = 1'b1;
            cmd.ptr_sel  = PTR_COMMIT;
            state_in     = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit_rd = 1'b1;
            if (status.commit_done) begin
               cmd.cursor_update = 1'b1;
               state_in          = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/gffp_datapath.sv @@
`timescale 1ns / 1ps
module gffp_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gffp_pkg::cmd_type                      cmd,
   input  logic [gffp_pkg::RSPAN_W-1:0]           row_start,
   input  logic [gffp_pkg::CSPAN_W-1:0]           column_start,
   input  logic [gffp_pkg::RSPAN_W-1:0]           row_span,
   input  logic [gffp_pkg::CSPAN_W-1:0]           column_span,
   input  logic [gffp_pkg::CNT_W-1:0]             column_count,
   input  logic                                   dense_mode,
   output gffp_pkg::status_type                   status,
   output logic [gffp_pkg::ROW_W-1:0]             placed_row,
   output logic [gffp_pkg::COL_W-1:0]             placed_column,
   output logic                                   overflow
);
   import gffp_pkg::*;

   logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
   logic [MAX_COLUMNS-1:0] rd_data_ff;
   logic [MAX_ROWS-1:0]    valid_ff;
   logic                   q_valid_ff;
   logic [ROW_W-1:0]       q_row_ff;
   logic                   pend_ff;
   logic [PTR_W-1:0]       ptr_ff;

   logic [RSPAN_W-1:0]     rspan_ff;
   logic [CSPAN_W-1:0]     cspan_ff;
   logic [CNT_W-1:0]       cc_ff;
   logic [PTR_W-1:0]       ex_row_ff;
   logic [COL_W-1:0]       ex_col_ff;
   logic                   dense_ff;
   logic                   conflict_ff;
   logic [PTR_W-1:0]       start_row_ff;
   logic [COL_W-1:0]       start_col_ff;
   logic [PTR_W-1:0]       run_ff [MAX_COLUMNS];
   logic                   found_ff;
   logic [ROW_W-1:0]       place_row_ff;
   logic [COL_W-1:0]       place_col_ff;
   logic                   ovf_ff;
   logic [PTR_W-1:0]       cursor_row_ff;
   logic [COL_W-1:0]       cursor_col_ff;

   logic [CNT_W-1:0]       cc_in;
   logic [RSPAN_W-1:0]     rspan_in;
   logic [CSPAN_W-1:0]     cspan_in;
   logic [CNT_W-1:0]       ex_col_raw;
   logic [COL_W-1:0]       ex_col_in;

   logic [MAX_COLUMNS-1:0] row_bits;
   logic [END_W-1:0]       ex_sum;
   logic [END_W-1:0]       ex_end;
   logic [END_W-1:0]       cm_end;
   logic                   rd_en;
   logic                   ex_proc;
   logic                   scan_proc;
   logic                   cm_proc;
   logic [MAX_COLUMNS-1:0] cm_mask;
   logic [PTR_W-1:0]       run_next [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0] run_ok;
   logic [MAX_COLUMNS-1:0] win_ok;
   logic [MAX_COLUMNS-1:0] win_mask;
   logic                   first_row;
   logic                   hit;
   logic [COL_W-1:0]       hit_col;
   logic [PTR_W-1:0]       hit_row;
   logic [CNT_W-1:0]       cursor_sum;

   always_comb begin
      if (column_count == '0) begin
         cc_in = CNT_W'(1);
      end else if (column_count > CNT_W'(MAX_COLUMNS)) begin
         cc_in = CNT_W'(MAX_COLUMNS);
      end else begin
         cc_in = column_count;
      end
      rspan_in = (row_span == '0) ? RSPAN_W'(1) : row_span;
      if (column_span == '0) begin
         cspan_in = CSPAN_W'(1);
      end else if (column_span > cc_in) begin
         cspan_in = cc_in;
      end else begin
         cspan_in = column_span;
      end
      ex_col_raw = column_start - CNT_W'(1);
      ex_col_in  = (ex_col_raw >= cc_in) ? COL_W'(cc_in - CNT_W'(1)) : ex_col_raw[COL_W-1:0];
   end

   assign row_bits = q_valid_ff ? rd_data_ff : '0;
   assign ex_sum   = END_W'(ex_row_ff) + END_W'(rspan_ff);
   assign ex_end   = (ex_sum > END_W'(MAX_ROWS)) ? END_W'(MAX_ROWS) : ex_sum;
   assign cm_end   = END_W'(place_row_ff) + END_W'(rspan_ff);
   assign cm_mask  = span_mask(place_col_ff, cspan_ff);

   always_comb begin
      rd_en = 1'b0;
      if (cmd.ex_rd) begin
         rd_en = END_W'(ptr_ff) < ex_end;
      end else if (cmd.scan_rd) begin
         rd_en = (ptr_ff < PTR_W'(MAX_ROWS)) && !found_ff;
      end else if (cmd.commit_rd) begin
         rd_en = END_W'(ptr_ff) < cm_end;
      end
   end

   assign ex_proc   = cmd.ex_rd && pend_ff;
   assign scan_proc = cmd.scan_rd && pend_ff && !found_ff;
   assign cm_proc   = cmd.commit_rd && pend_ff;

   always_comb begin
      for (int j = 0; j < MAX_COLUMNS; j++) begin
         run_next[j] = row_bits[j] ? '0 : run_ff[j] + PTR_W'(1);
         run_ok[j]   = run_next[j] >= rspan_ff;
      end
      first_row = (END_W'(q_row_ff) + END_W'(1)) == (END_W'(start_row_ff) + END_W'(rspan_ff));
      for (int c = 0; c < MAX_COLUMNS; c++) begin
         win_mask  = span_mask(COL_W'(c), cspan_ff);
         win_ok[c] = ((CNT_W'(c) + cspan_ff) <= cc_ff) && ((run_ok & win_mask) == win_mask)
                     && (!first_row || (COL_W'(c) >= start_col_ff));
      end
      hit     = |win_ok;
      hit_col = '0;
      for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
         if (win_ok[c]) begin
            hit_col = COL_W'(c);
         end
      end
      hit_row    = PTR_W'(q_row_ff) + PTR_W'(1) - rspan_ff;
      cursor_sum = CNT_W'(place_col_ff) + cspan_ff;
   end

   always_ff @(posedge clock) begin
      if (cm_proc) begin
         mem[q_row_ff] <= row_bits | cm_mask;
      end
      rd_data_ff <= mem[ptr_ff[ROW_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         pend_ff       <= 1'b0;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         found_ff      <= 1'b0;
         ovf_ff        <= 1'b0;
         conflict_ff   <= 1'b0;
      end else begin
         pend_ff <= rd_en;
         if (cmd.clear) begin
            valid_ff      <= '0;
            cursor_row_ff <= '0;
            cursor_col_ff <= '0;
         end else if (cm_proc) begin
            valid_ff[q_row_ff] <= 1'b1;
         end
         if (cmd.load) begin
            ovf_ff      <= 1'b0;
            conflict_ff <= 1'b0;
            found_ff    <= 1'b0;
         end else begin
            if (cmd.mark_overflow) begin
               ovf_ff <= 1'b1;
            end
            if (ex_proc && ((row_bits & span_mask(ex_col_ff, cspan_ff)) != '0)) begin
               conflict_ff <= 1'b1;
            end
            if (cmd.ptr_load && cmd.ptr_sel == PTR_SCAN) begin
               found_ff <= 1'b0;
            end else if (scan_proc && hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.cursor_update && !dense_ff) begin
            if (cursor_sum >= cc_ff) begin
               cursor_row_ff <= PTR_W'(place_row_ff) + PTR_W'(1);
               cursor_col_ff <= '0;
            end else begin
               cursor_row_ff <= PTR_W'(place_row_ff);
               cursor_col_ff <= cursor_sum[COL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      q_valid_ff <= valid_ff[ptr_ff[ROW_W-1:0]];
      q_row_ff   <= ptr_ff[ROW_W-1:0];
      if (rd_en) begin
         ptr_ff <= ptr_ff + PTR_W'(1);
      end else if (cmd.ptr_load) begin
         unique case (cmd.ptr_sel)
            PTR_EXPLICIT: ptr_ff <= row_start - RSPAN_W'(1);
            PTR_SCAN:     ptr_ff <= dense_ff ? '0 : cursor_row_ff;
            PTR_COMMIT:   ptr_ff <= PTR_W'(place_row_ff);
            default:      ptr_ff <= '0;
         endcase
      end
      if (cmd.load) begin
         rspan_ff     <= rspan_in;
         cspan_ff     <= cspan_in;
         cc_ff        <= cc_in;
         ex_row_ff    <= row_start - RSPAN_W'(1);
         ex_col_ff    <= ex_col_in;
         dense_ff     <= dense_mode;
         place_row_ff <= '0;
         place_col_ff <= '0;
      end else if (cmd.take_explicit) begin
         place_row_ff <= ex_row_ff[ROW_W-1:0];
         place_col_ff <= ex_col_ff;
      end else if (scan_proc && hit) begin
         place_row_ff <= hit_row[ROW_W-1:0];
         place_col_ff <= hit_col;
      end
      if (cmd.ptr_load && cmd.ptr_sel == PTR_SCAN) begin
         start_row_ff <= dense_ff ? '0 : cursor_row_ff;
         start_col_ff <= dense_ff ? '0 : cursor_col_ff;
         for (int j = 0; j < MAX_COLUMNS; j++) begin
            run_ff[j] <= '0;
         end
      end else if (scan_proc) begin
         for (int j = 0; j < MAX_COLUMNS; j++) begin
            run_ff[j] <= run_next[j];
         end
      end
   end

   always_comb begin
      status              = '0;
      status.explicit_req = (row_start != '0) && (column_start != '0);
      status.ex_done      = (END_W'(ptr_ff) >= ex_end) && !pend_ff;
      status.ex_fit       = !conflict_ff && ((CNT_W'(ex_col_ff) + cspan_ff) <= cc_ff);
      status.ex_overflow  = ex_sum > END_W'(MAX_ROWS);
      status.scan_done    = (found_ff || (ptr_ff >= PTR_W'(MAX_ROWS))) && !pend_ff;
      status.scan_found   = found_ff;
      status.commit_done  = (END_W'(ptr_ff) >= cm_end) && !pend_ff;
   end

   assign placed_row    = ovf_ff ? '0 : place_row_ff;
   assign placed_column = ovf_ff ? '0 : place_col_ff;
   assign overflow      = ovf_ff;

endmodule

@@ src/grid_first_fit_placer.sv @@
`timescale 1ns / 1ps
// Places rectangles first-fit on a 64-row by 16-column occupancy grid, one request at a time.
// A request is taken only while the block is idle; its result goes to an output register, so
// the next request can be taken while that result still waits. The grid lives in a memory with
// separate read and write ports, read one row per cycle, which sets the time per item: a clear
// goes straight to its result; an explicit position that fits is read over its R rows (R = row
// span) and then written over them; an automatic search reads rows from the start row down to
// the item's last row and then writes the item, after first checking an explicit position over
// its rows when one was given and did not fit. An overflow skips the write and ends the item as
// soon as it is known. A result that cannot leave holds the block until the output register
// frees up. Per-row valid bits make reset and clear take effect at once; there is no clearing
// pass.
module grid_first_fit_placer (
   input  logic                                 clock,
   input  logic                                 reset,
   // tdata: row_start[6:0], column_start[11:7], row_span[18:12], column_span[23:19]
   input  logic [gffp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: req_type
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tdata: placed_row[5:0], placed_column[9:6], zero[15:10]
   output logic [gffp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: overflow
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gffp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [gffp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [gffp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import gffp_pkg::*;

   logic [CNT_W-1:0]      column_count_ff;
   logic                  dense_mode_ff;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;
   logic                  csr_write;
   logic                  csr_index;
   logic                  req_fire;
   logic                  req_ready;
   cmd_type               cmd;
   status_type            status;
   logic [ROW_W-1:0]      placed_row;
   logic [COL_W-1:0]      placed_column;
   logic                  overflow;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= CNT_W'(MAX_COLUMNS);
         dense_mode_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COLUMN_COUNT: column_count_ff <= csr_pwdata[CNT_W-1:0];
            REG_DENSE_MODE:   dense_mode_ff   <= csr_pwdata[0];
            default:          dense_mode_ff   <= dense_mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COLUMN_COUNT: csr_prdata = CSR_DATA_W'(column_count_ff);
         REG_DENSE_MODE:   csr_prdata = CSR_DATA_W'(dense_mode_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign req_tready = req_ready;
   assign req_fire   = req_tvalid && req_ready;

   gffp_controller u_controller (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_clear     (req_tuser == REQ_CLEAR),
      .rsp_slot_free (!rsp_valid_ff || rsp_tready),
      .status        (status),
      .req_ready     (req_ready),
      .cmd           (cmd)
   );

   gffp_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .row_start     (req_tdata[6:0]),
      .column_start  (req_tdata[11:7]),
      .row_span      (req_tdata[18:12]),
      .column_span   (req_tdata[23:19]),
      .column_count  (column_count_ff),
      .dense_mode    (dense_mode_ff),
      .status        (status),
      .placed_row    (placed_row),
      .placed_column (placed_column),
      .overflow      (overflow)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= RSP_DATA_W'({placed_column, placed_row});
         rsp_user_ff <= overflow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ tb/tb_grid_first_fit_placer.sv @@
`timescale 1ns / 1ps
module tb_grid_first_fit_placer;
   import gffp_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   grid_first_fit_placer dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct packed {
      logic       kind;
      logic [6:0] row_start;
      logic [4:0] col_start;
      logic [6:0] row_span;
      logic [4:0] col_span;
   } placement_req_type;

   typedef struct packed {
      logic [5:0] row;
      logic [3:0] col;
      logic       ovf;
   } placement_type;

   typedef struct packed {
      logic       check;
      logic [4:0] cols;
      logic       dense;
      placement_req_type rq;
      placement_type     res;
   } stim_row_type;

   logic [MAX_COLUMNS-1:0] grid_model [MAX_ROWS];
   int unsigned            cur_row, cur_col, model_cols, model_dense;
   placement_type          placement_q [$];
   logic                   fixed_q [$];
   placement_type          fixed_res_q [$];
   int                     mismatches = 0;
   int                     rsp_idle = 0;
   int                     req_idle = 0;

   function automatic bit fits(int unsigned r, int unsigned c, int unsigned rs,
                               int unsigned cs, int unsigned cc);
      logic [MAX_COLUMNS-1:0] m;
      if (c + cs > cc) return 0;
      m = span_mask(COL_W'(c), CSPAN_W'(cs));
      for (int unsigned i = r; i < r + rs && i < MAX_ROWS; i++)
         if ((grid_model[i] & m) != 0) return 0;
      return 1;
   endfunction

   function automatic placement_type place_item(placement_req_type rq);
      placement_type p;
      int unsigned   cc, rs, cs, row, col, first, sr, sc;
      bit            found;
      logic [MAX_COLUMNS-1:0] m;
      p = '0;
      found = 0;
      row = 0;
      col = 0;
      if (rq.kind == REQ_CLEAR) begin
         foreach (grid_model[i]) grid_model[i] = '0;
         cur_row = 0;
         cur_col = 0;
         return p;
      end
      cc = model_cols < 1 ? 1 : (model_cols > MAX_COLUMNS ? MAX_COLUMNS : model_cols);
      rs = rq.row_span < 1 ? 1 : rq.row_span;
      cs = rq.col_span < 1 ? 1 : rq.col_span;
      if (cs > cc) cs = cc;
      if (rq.row_start > 0 && rq.col_start > 0) begin
         row = rq.row_start - 1;
         col = rq.col_start - 1;
         if (col >= cc) col = cc - 1;
         found = fits(row, col, rs, cs, cc);
      end
      if (!found) begin
         sr = model_dense ? 0 : cur_row;
         sc = model_dense ? 0 : cur_col;
         for (int unsigned r = sr; r < MAX_ROWS && !found; r++) begin
            first = (r == sr) ? sc : 0;
            for (int unsigned c = first; c < cc && !found; c++)
               if (fits(r, c, rs, cs, cc)) begin
                  row = r;
                  col = c;
                  found = 1;
               end
         end
      end
      if (!found || row + rs > MAX_ROWS) begin
         p.ovf = 1'b1;
         return p;
      end
      m = span_mask(COL_W'(col), CSPAN_W'(cs));
      for (int unsigned r = row; r < row + rs; r++) grid_model[r] |= m;
      if (!model_dense) begin
         cur_row = row;
         cur_col = col + cs;
         if (cur_col >= cc) begin
            cur_row = row + 1;
            cur_col = 0;
         end
      end
      p.row = row[5:0];
      p.col = col[3:0];
      return p;
   endfunction

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(int unsigned cols, int unsigned dense);
      req_tvalid <= 1'b0;
      while (placement_q.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      csr_write(3'(4 * REG_COLUMN_COUNT), cols);
      csr_write(3'(4 * REG_DENSE_MODE), dense);
      model_cols = cols & 31;
      model_dense = dense & 1;
   endtask

   task automatic send(placement_req_type rq, bit chk, placement_type res);
      while (req_idle > 0 && $urandom_range(99) < req_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rq.kind;
      req_tdata <= {rq.col_span, rq.row_span, rq.col_start, rq.row_start};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      placement_q.insert(placement_q.size(), place_item(rq));
      fixed_q.insert(fixed_q.size(), chk);
      fixed_res_q.insert(fixed_res_q.size(), res);
      @(negedge clock);
   endtask

   always @(negedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_idle);

   always @(posedge clock) begin
      placement_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{row: rsp_tdata[5:0], col: rsp_tdata[9:6], ovf: rsp_tuser};
         if (placement_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = placement_q.pop_front();
            if (fixed_q.pop_front()) want = fixed_res_q.pop_front();
            else void'(fixed_res_q.pop_front());
            if (got !== want || rsp_tdata[15:10] !== '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   function automatic placement_req_type rand_req();
      placement_req_type rq;
      rq.kind = ($urandom_range(99) < 3) ? REQ_CLEAR : REQ_PLACE;
      rq.row_start = ($urandom_range(1)) ? 7'd0 : 7'($urandom_range(0, 64));
      rq.col_start = ($urandom_range(1)) ? 5'd0 : 5'($urandom_range(0, 16));
      rq.row_span = ($urandom_range(9) == 0) ? 7'($urandom_range(0, 64))
                                             : 7'($urandom_range(0, 4));
      rq.col_span = 5'($urandom_range(0, 16));
      if ($urandom_range(49) == 0) begin
         rq.row_start = 7'($urandom);
         rq.col_start = 5'($urandom);
         rq.row_span = 7'($urandom);
         rq.col_span = 5'($urandom);
      end
      return rq;
   endfunction

   stim_row_type directed [20] = '{
      '{1, 16, 0, '{REQ_PLACE, 0, 0, 1, 1},    '{0, 0, 0}},
      '{1, 16, 0, '{REQ_PLACE, 0, 0, 0, 0},    '{0, 1, 0}},
      '{1, 16, 0, '{REQ_PLACE, 64, 16, 1, 1},  '{63, 15, 0}},
      '{1, 16, 0, '{REQ_PLACE, 64, 1, 2, 1},   '{0, 0, 1}},
      '{1, 16, 0, '{REQ_CLEAR, 5, 5, 5, 5},    '{0, 0, 0}},
      '{0, 16, 0, '{REQ_PLACE, 0, 0, 64, 16},  '{0, 0, 0}},
      '{0, 16, 0, '{REQ_PLACE, 0, 0, 1, 1},    '{0, 0, 0}},
      '{1, 16, 0, '{REQ_CLEAR, 0, 0, 0, 0},    '{0, 0, 0}},
      '{0, 16, 0, '{REQ_PLACE, 3, 31, 2, 31},  '{0, 0, 0}},
      '{0, 16, 0, '{REQ_PLACE, 3, 4, 2, 2},    '{0, 0, 0}},
      '{0, 16, 0, '{REQ_PLACE, 127, 1, 127, 1}, '{0, 0, 0}},
      '{0, 16, 0, '{REQ_PLACE, 64, 16, 1, 1},  '{0, 0, 0}},
      '{0, 16, 0, '{REQ_PLACE, 0, 0, 1, 1},    '{0, 0, 0}},
      '{0, 16, 1, '{REQ_PLACE, 0, 0, 1, 3},    '{0, 0, 0}},
      '{0, 16, 1, '{REQ_PLACE, 0, 5, 1, 1},    '{0, 0, 0}},
      '{0, 0, 0,  '{REQ_PLACE, 0, 0, 1, 16},   '{0, 0, 0}},
      '{0, 0, 0,  '{REQ_PLACE, 2, 9, 1, 0},    '{0, 0, 0}},
      '{0, 4, 0,  '{REQ_PLACE, 0, 0, 1, 1},    '{0, 0, 0}},
      '{0, 31, 0, '{REQ_PLACE, 0, 0, 2, 16},   '{0, 0, 0}},
      '{1, 16, 0, '{REQ_CLEAR, 0, 0, 0, 0},    '{0, 0, 0}}
   };

   initial begin
      placement_req_type rq;
      int unsigned       cfg_cols, cfg_dense;
      model_cols = 16;
      model_dense = 0;
      cur_row = 0;
      cur_col = 0;
      foreach (grid_model[i]) grid_model[i] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      cfg_cols = 16;
      cfg_dense = 0;
      foreach (directed[i]) begin
         if (directed[i].cols != cfg_cols || directed[i].dense != cfg_dense) begin
            cfg_cols = directed[i].cols;
            cfg_dense = directed[i].dense;
            configure(cfg_cols, cfg_dense);
         end
         send(directed[i].rq, directed[i].check, directed[i].res);
      end
      for (int i = 0; i < 1450; i++) begin
         if (i == 480) begin req_idle = 55; rsp_idle = 38; end
         else if (i == 960) begin req_idle = 0; rsp_idle = 0; end
         else if (i == 0) begin req_idle = 38; rsp_idle = 55; end
         if (i % 120 == 0) begin
            unique case ((i / 120) % 5)
               0: configure(16, 0);
               1: configure(1, 1);
               2: configure($urandom_range(2, 15), $urandom_range(1));
               3: configure(0, 0);
               default: configure($urandom_range(0, 31), $urandom_range(1));
            endcase
         end
         rq = rand_req();
         send(rq, 1'b0, '0);
      end
      req_tvalid <= 1'b0;
      while (placement_q.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      if (mismatches == 0) begin
         $display("grid_first_fit_placer test passed");
      end else begin
         $display("grid_first_fit_placer test failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("grid_first_fit_placer test failed");
      $finish;
   end

endmodule
